// ===== sv/mdm_pkg.sv =====
// ----------------------------------------------------------------------------
// mdm_pkg: shared types and constants for the mecanum drive mixer
// Register map, tick timer width, drive pattern values and the reciprocal
// used to divide the scaled speed by the span constant.
// ----------------------------------------------------------------------------
package mdm_pkg;

    // Width of the command age and back-off hold timers
    localparam int TICK_W = 16;
    // Largest timer value (all ones in TICK_W bits)
    localparam logic [31:0] TICK_MAX = 32'((64'd1 << TICK_W) - 64'd1);

    // Register indexes (byte address bits [3:2])
    typedef enum logic [1:0] {
        REG_DRIVE_MODE = 2'd0,
        REG_MAX_PWM    = 2'd1,
        REG_CMD_TMO    = 2'd2,
        REG_AVOID_HOLD = 2'd3
    } t_reg_idx;

    // Register reset values
    localparam logic        RST_DRIVE_MODE = 1'b0;
    localparam logic [13:0] RST_MAX_PWM    = 14'd10000;
    localparam logic [15:0] RST_CMD_TMO    = 16'd150;
    localparam logic [15:0] RST_AVOID_HOLD = 16'd1000;

    // Speed offset that moves the command range onto zero
    localparam logic signed [15:0] SPEED_SPAN = 16'sd3000;

    // Fixed self-driving patterns
    localparam logic signed [18:0] BACK_SLOW = -19'sd1500;
    localparam logic signed [18:0] BACK_FAST = -19'sd4500;
    localparam logic signed [18:0] CRUISE    = 19'sd3500;

    // floor(n / 3000) = (n * RECIP) >> RECIP_SH, exact for n < 2^28
    localparam int          RECIP_SH = 40;
    localparam logic [28:0] RECIP    = 29'd366503876;

    // Control bits that travel with one word down the pipeline
    typedef struct packed {
        logic       lost;
        logic       hold_l;
        logic       hold_r;
        logic [3:0] obs;     // left_down, left_up, right_up, right_down
    } t_ctl;

endpackage

// ===== sv/mecanum_drive_mixer_with_guard.sv =====
// ----------------------------------------------------------------------------
// mecanum_drive_mixer_with_guard: mecanum wheel mixer with obstacle guard
// Ages the command link, runs the back-off hold timers, mixes X/Y/rotation
// into four wheel drives, scales them and forces a stop near obstacles.
// ----------------------------------------------------------------------------
// Usage:
//   One input word per control period on s_axis (ticks elapsed, command flag,
//   speed command, four obstacle sensors). One result word per input word on
//   m_axis (four drives, stopped, link_lost), in order.
//   Configuration goes through the APB port (mode, max_pwm, timeout, hold);
//   the user writes it only while no word is in flight; nothing enforces it.
// Timing:
//   Four register stages lie between input accept and output valid, loaded
//   in turn: mix (at the accept edge), magnitude multiply, reciprocal
//   multiply, sign/offset/guard. Throughput is one word per cycle unless
//   m_axis stalls; the two multiplier stages per wheel set the pipeline depth.
//   Timer state updates at the accept edge, so back-to-back words chain.
// Reset:
//   Clears the command age, both hold timers and all pipeline valid bits;
//   registers return to mode 0, max_pwm 10000, timeout 150, hold 1000.
// Stall:
//   While m_axis_tready is low a valid result holds; earlier stages keep
//   filling bubbles and s_axis_tready drops only when every stage is full.
// ----------------------------------------------------------------------------
module mecanum_drive_mixer_with_guard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] tick_delta, [8] command_seen, [21:9] speed_x, [34:22] speed_y,
    // [47:35] speed_z, [48] obstacle_left_down, [49] obstacle_left_up,
    // [50] obstacle_right_up, [51] obstacle_right_down, [55:52] zero
    input  logic [55:0] s_axis_tdata,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] drive_a, [31:16] drive_b, [47:32] drive_c, [63:48] drive_d,
    // [64] stopped, [65] link_lost, [71:66] zero
    output logic [71:0] m_axis_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TW = mdm_pkg::TICK_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        r_drive_mode;
    logic [13:0] r_max_pwm;
    logic [15:0] r_cmd_tmo;
    logic [15:0] r_avoid_hold;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_mode <= mdm_pkg::RST_DRIVE_MODE;
            r_max_pwm    <= mdm_pkg::RST_MAX_PWM;
            r_cmd_tmo    <= mdm_pkg::RST_CMD_TMO;
            r_avoid_hold <= mdm_pkg::RST_AVOID_HOLD;
        end else if (cfg_wr) begin
            case (cfg_idx)
                mdm_pkg::REG_DRIVE_MODE: r_drive_mode <= pwdata[0];
                mdm_pkg::REG_MAX_PWM:    r_max_pwm    <= pwdata[13:0];
                mdm_pkg::REG_CMD_TMO:    r_cmd_tmo    <= pwdata[15:0];
                mdm_pkg::REG_AVOID_HOLD: r_avoid_hold <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        case (cfg_idx)
            mdm_pkg::REG_DRIVE_MODE: prdata = {31'd0, r_drive_mode};
            mdm_pkg::REG_MAX_PWM:    prdata = {18'd0, r_max_pwm};
            mdm_pkg::REG_CMD_TMO:    prdata = {16'd0, r_cmd_tmo};
            mdm_pkg::REG_AVOID_HOLD: prdata = {16'd0, r_avoid_hold};
            default:                 prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: a stage loads when it is empty or drains
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_vo;
    logic en1, en2, en3, en_o;
    logic in_acc;

    assign en_o          = !r_vo || m_axis_tready;
    assign en3           = !r_v3 || en_o;
    assign en2           = !r_v2 || en3;
    assign en1           = !r_v1 || en2;
    assign s_axis_tready = en1;
    assign in_acc        = s_axis_tvalid && en1;
    assign m_axis_tvalid = r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1)  r_v1 <= s_axis_tvalid;
            if (en2)  r_v2 <= r_v1;
            if (en3)  r_v3 <= r_v2;
            if (en_o) r_vo <= r_v3;
        end
    end

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic [7:0]         tick_delta;
    logic               command_seen;
    logic signed [12:0] speed_x, speed_y, speed_z;
    logic [3:0]         obs_in;

    assign tick_delta   = s_axis_tdata[7:0];
    assign command_seen = s_axis_tdata[8];
    assign speed_x      = $signed(s_axis_tdata[21:9]);
    assign speed_y      = $signed(s_axis_tdata[34:22]);
    assign speed_z      = $signed(s_axis_tdata[47:35]);
    assign obs_in       = s_axis_tdata[51:48];

    // ------------------------------------------------------------------
    // Link age and hold timers, updated at each accepted word
    // ------------------------------------------------------------------
    logic [TW-1:0] r_cmd_age, r_hold_l, r_hold_r;
    logic [TW-1:0] n_cmd_age, n_hold_l, n_hold_r;
    logic [TW:0]   age_sum;
    logic [TW-1:0] reload;
    logic          lost_in;

    always_comb begin
        // Advance the age, saturating at all ones; restart on a command
        age_sum = {1'b0, r_cmd_age} + (TW+1)'(tick_delta);
        if (command_seen) begin
            n_cmd_age = '0;
        end else if (age_sum[TW]) begin
            n_cmd_age = '1;
        end else begin
            n_cmd_age = age_sum[TW-1:0];
        end
        lost_in = 32'(n_cmd_age) > 32'(r_cmd_tmo);

        // Count both holds down, stopping at zero
        n_hold_l = (32'(r_hold_l) > 32'(tick_delta)) ? r_hold_l - TW'(tick_delta) : '0;
        n_hold_r = (32'(r_hold_r) > 32'(tick_delta)) ? r_hold_r - TW'(tick_delta) : '0;

        // Retrigger from the front sensors in self mode without a link
        reload = (32'(r_avoid_hold) > mdm_pkg::TICK_MAX) ?
                 TW'(mdm_pkg::TICK_MAX) : TW'(r_avoid_hold);
        if (r_drive_mode && lost_in) begin
            if (obs_in[1]) n_hold_l = reload;
            if (obs_in[2]) n_hold_r = reload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_age <= '0;
            r_hold_l  <= '0;
            r_hold_r  <= '0;
        end else if (in_acc) begin
            r_cmd_age <= n_cmd_age;
            r_hold_l  <= n_hold_l;
            r_hold_r  <= n_hold_r;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: mix the speeds and offset by the span
    // ------------------------------------------------------------------
    logic signed [15:0] sx, sy, sz;
    logic signed [15:0] n_p1 [4];
    logic signed [15:0] r_p1 [4];
    mdm_pkg::t_ctl      n_ctl1, r_ctl1;

    always_comb begin
        sx = 16'(speed_x);
        sy = 16'(speed_y);
        sz = 16'(speed_z);
        n_p1[0] = -sx + sy + sz + mdm_pkg::SPEED_SPAN;
        n_p1[1] =  sx + sy + sz + mdm_pkg::SPEED_SPAN;
        n_p1[2] = -sx + sy - sz + mdm_pkg::SPEED_SPAN;
        n_p1[3] =  sx + sy - sz + mdm_pkg::SPEED_SPAN;
        n_ctl1.lost   = lost_in;
        n_ctl1.hold_l = n_hold_l != '0;
        n_ctl1.hold_r = n_hold_r != '0;
        n_ctl1.obs    = obs_in;
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_p1   <= n_p1;
            r_ctl1 <= n_ctl1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitude times max_pwm
    // ------------------------------------------------------------------
    logic [14:0]   mag1 [4];
    logic [27:0]   r_n2 [4];
    logic [3:0]    r_neg2;
    mdm_pkg::t_ctl r_ctl2;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mag1[i] = r_p1[i][15] ? 15'(-r_p1[i]) : 15'(r_p1[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int i = 0; i < 4; i++) begin
                r_n2[i]   <= 28'(mag1[i]) * 28'(r_max_pwm);
                r_neg2[i] <= r_p1[i][15];
            end
            r_ctl2 <= r_ctl1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: divide by the span through the reciprocal
    // ------------------------------------------------------------------
    logic [56:0]   prod3 [4];
    logic [16:0]   r_q3  [4];
    logic [3:0]    r_neg3;
    mdm_pkg::t_ctl r_ctl3;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            prod3[i] = 57'(r_n2[i]) * 57'(mdm_pkg::RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            for (int i = 0; i < 4; i++) begin
                r_q3[i] <= prod3[i][mdm_pkg::RECIP_SH +: 17];
            end
            r_neg3 <= r_neg2;
            r_ctl3 <= r_ctl2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: restore sign, remove offset, pick source, apply guard
    // ------------------------------------------------------------------
    logic signed [18:0] qs  [4];
    logic signed [18:0] drv [4];
    logic signed [18:0] mxs;
    logic               stop;
    logic [15:0]        r_drv [4];
    logic               r_stop, r_lost;

    always_comb begin
        mxs = $signed({5'd0, r_max_pwm});
        for (int i = 0; i < 4; i++) begin
            qs[i] = $signed({2'b00, r_q3[i]});
            if (r_neg3[i]) qs[i] = -qs[i];
        end
        // Choose between command, zero and the self-driving pattern
        for (int i = 0; i < 4; i++) begin
            if (!r_ctl3.lost) begin
                drv[i] = qs[i] - mxs;
            end else if (!r_drive_mode) begin
                drv[i] = '0;
            end else if (r_ctl3.hold_l) begin
                drv[i] = (i < 2) ? mdm_pkg::BACK_SLOW : mdm_pkg::BACK_FAST;
            end else if (r_ctl3.hold_r) begin
                drv[i] = (i < 2) ? mdm_pkg::BACK_FAST : mdm_pkg::BACK_SLOW;
            end else begin
                drv[i] = mdm_pkg::CRUISE;
            end
        end
        // Stop when a wheel pushes toward an active sensor
        stop = (r_ctl3.obs[0] && drv[0] < 0) || (r_ctl3.obs[1] && drv[1] > 0) ||
               (r_ctl3.obs[3] && drv[2] < 0) || (r_ctl3.obs[2] && drv[3] > 0);
        if (stop) begin
            for (int i = 0; i < 4; i++) drv[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            for (int i = 0; i < 4; i++) r_drv[i] <= drv[i][15:0];
            r_stop <= stop;
            r_lost <= r_ctl3.lost;
        end
    end

    assign m_axis_tdata = {6'd0, r_lost, r_stop, r_drv[3], r_drv[2], r_drv[1], r_drv[0]};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // A stop result carries four zero drives
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && r_stop) |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("stop result with nonzero drive");

    // Lost link in pwm mode gives zero drives and no stop
    a_lost_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && r_lost && !r_drive_mode) |->
        (m_axis_tdata[63:0] == 64'd0 && !r_stop))
        else $error("lost link in pwm mode drives wheels");

    // Input side only stalls when the output holds a word
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vo |-> s_axis_tready)
        else $error("input stalled with empty output");

    // A fresh command restarts the link age
    a_age_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && command_seen) |=> (r_cmd_age == '0))
        else $error("command age not restarted");
`endif

endmodule

// ===== verif/mdm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mdm_checker: scoreboard for the mecanum drive mixer
// Watches the input stream, the result stream and the APB port. Keeps its own
// copy of the registers, the command age and the two back-off hold timers,
// predicts the wheel drives of every accepted input word and compares each
// accepted result word with the oldest prediction. Register reads are
// compared against the shadow copy.
// ----------------------------------------------------------------------------
module mdm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [55:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [71:0] i_m_tdata,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_pending,
    output int          o_fail_count
);

    // One result word, highest bits first: link_lost, stopped, four drives
    // (A lowest)
    typedef struct packed {
        logic             link_lost;
        logic             stopped;
        logic [3:0][15:0] drive;
    } wheel_cmd_t;

    wheel_cmd_t  wheel_cmd_q[$];

    // Wheel letters for messages
    string       wheel_names = "ABCD";

    // Shadow registers
    logic        self_mode;
    logic [13:0] pwm_full;
    logic [15:0] link_timeout;
    logic [15:0] backoff_ticks;

    // Timer state
    longint      cmd_age;
    longint      hold_left;
    longint      hold_right;

    int          fail_cnt = 0;
    int          word_idx;

    assign o_fail_count = fail_cnt;

    // Print one mismatch line and count it
    task automatic report(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        fail_cnt++;
    endtask

    // Scale one mixed speed onto the drive range, truncating toward zero
    function automatic longint scale_speed(input longint v, input longint full);
        longint span;
        span = mdm_pkg::SPEED_SPAN;
        return ((v + span) * 2 * full) / (2 * span) - full;
    endfunction

    // Register value as a read returns it
    function automatic logic [31:0] reg_value(input mdm_pkg::t_reg_idx idx);
        case (idx)
            mdm_pkg::REG_DRIVE_MODE: return {31'd0, self_mode};
            mdm_pkg::REG_MAX_PWM:    return {18'd0, pwm_full};
            mdm_pkg::REG_CMD_TMO:    return {16'd0, link_timeout};
            default:                 return {16'd0, backoff_ticks};
        endcase
    endfunction

    // Advance the timers by one control period and work out its drives
    task automatic mix_period(input logic [55:0] w, output wheel_cmd_t res);
        longint delta, x, y, z, reload;
        longint d [4];
        logic   lost, stop, ld, lu, ru, rd;
        delta = w[7:0];
        x     = $signed(w[21:9]);
        y     = $signed(w[34:22]);
        z     = $signed(w[47:35]);
        ld    = w[48];
        lu    = w[49];
        ru    = w[50];
        rd    = w[51];

        // age the link, saturating at the timer width
        if (w[8]) begin
            cmd_age = 0;
        end else begin
            cmd_age += delta;
            if (cmd_age > mdm_pkg::TICK_MAX) cmd_age = mdm_pkg::TICK_MAX;
        end
        lost = cmd_age > link_timeout;

        // count both hold timers down in every mode
        hold_left  = (hold_left > delta) ? hold_left - delta : 0;
        hold_right = (hold_right > delta) ? hold_right - delta : 0;

        if (!lost) begin
            d[0] = scale_speed(-x + y + z, pwm_full);
            d[1] = scale_speed(x + y + z, pwm_full);
            d[2] = scale_speed(-x + y - z, pwm_full);
            d[3] = scale_speed(x + y - z, pwm_full);
        end else if (!self_mode) begin
            for (int i = 0; i < 4; i++) d[i] = 0;
        end else begin
            // front sensors retrigger the back-off
            reload = backoff_ticks;
            if (reload > mdm_pkg::TICK_MAX) reload = mdm_pkg::TICK_MAX;
            if (lu) hold_left = reload;
            if (ru) hold_right = reload;
            if (hold_left > 0) begin
                d[0] = mdm_pkg::BACK_SLOW;
                d[1] = mdm_pkg::BACK_SLOW;
                d[2] = mdm_pkg::BACK_FAST;
                d[3] = mdm_pkg::BACK_FAST;
            end else if (hold_right > 0) begin
                d[0] = mdm_pkg::BACK_FAST;
                d[1] = mdm_pkg::BACK_FAST;
                d[2] = mdm_pkg::BACK_SLOW;
                d[3] = mdm_pkg::BACK_SLOW;
            end else begin
                for (int i = 0; i < 4; i++) d[i] = mdm_pkg::CRUISE;
            end
        end

        // guard on the full-precision drives
        stop = (ld && d[0] < 0) || (lu && d[1] > 0) || (rd && d[2] < 0) || (ru && d[3] > 0);
        for (int i = 0; i < 4; i++) res.drive[i] = stop ? 16'd0 : d[i][15:0];
        res.stopped   = stop;
        res.link_lost = lost;
    endtask

    // Track registers, predict on input words, compare on result words
    always @(posedge i_clk) begin
        wheel_cmd_t want, got;
        if (!i_rst_n) begin
            self_mode     = mdm_pkg::RST_DRIVE_MODE;
            pwm_full      = mdm_pkg::RST_MAX_PWM;
            link_timeout  = mdm_pkg::RST_CMD_TMO;
            backoff_ticks = mdm_pkg::RST_AVOID_HOLD;
            cmd_age       = 0;
            hold_left     = 0;
            hold_right    = 0;
            word_idx      = 0;
            wheel_cmd_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (mdm_pkg::t_reg_idx'(i_paddr[3:2]))
                        mdm_pkg::REG_DRIVE_MODE: self_mode     = i_pwdata[0];
                        mdm_pkg::REG_MAX_PWM:    pwm_full      = i_pwdata[13:0];
                        mdm_pkg::REG_CMD_TMO:    link_timeout  = i_pwdata[15:0];
                        default:                 backoff_ticks = i_pwdata[15:0];
                    endcase
                end else if (i_prdata !== reg_value(mdm_pkg::t_reg_idx'(i_paddr[3:2]))) begin
                    report($sformatf("read of register %0d: got %0h expected %0h",
                        i_paddr[3:2], i_prdata,
                        reg_value(mdm_pkg::t_reg_idx'(i_paddr[3:2]))));
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                mix_period(i_s_tdata, want);
                wheel_cmd_q.push_back(want);
            end

            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[65:0];
                if (wheel_cmd_q.size() == 0) begin
                    report($sformatf("result word %0d with no input pending", word_idx));
                end else begin
                    want = wheel_cmd_q.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (got.drive[i] !== want.drive[i])
                            report($sformatf("word %0d drive %s: got %0d expected %0d",
                                word_idx, wheel_names.substr(i, i), $signed(got.drive[i]),
                                $signed(want.drive[i])));
                    end
                    if (got.stopped !== want.stopped)
                        report($sformatf("word %0d stopped: got %b expected %b",
                            word_idx, got.stopped, want.stopped));
                    if (got.link_lost !== want.link_lost)
                        report($sformatf("word %0d link_lost: got %b expected %b",
                            word_idx, got.link_lost, want.link_lost));
                end
                word_idx++;
            end
        end
        o_pending <= wheel_cmd_q.size();
    end

endmodule

// ===== verif/tb_mecanum_drive_mixer_with_guard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mecanum_drive_mixer_with_guard: stimulus and verdict for the drive mixer
// Drives control period words into the mixer with random gaps and random
// result backpressure, walks the registers through several settings over
// APB, and leaves all prediction and comparison to mdm_checker.
// ----------------------------------------------------------------------------
module tb_mecanum_drive_mixer_with_guard;

    // Drive mode values
    localparam logic [31:0] REMOTE_PWM = 32'd0;
    localparam logic [31:0] SELF_DRIVE = 32'd1;

    // Obstacle sensor bits within the sensor nibble
    localparam logic [3:0] OBS_NONE = 4'b0000;
    localparam logic [3:0] OBS_LD   = 4'b0001;
    localparam logic [3:0] OBS_LU   = 4'b0010;
    localparam logic [3:0] OBS_RU   = 4'b0100;
    localparam logic [3:0] OBS_RD   = 4'b1000;
    localparam logic [3:0] OBS_ALL  = 4'b1111;

    localparam int PHASES = 8;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int          pending;
    int          fail_count;
    bit          idle_on = 1'b1;

    mecanum_drive_mixer_with_guard u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mdm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop on a hung run
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Pack one control period word: delta, command flag, x, y, z, sensors
    function automatic logic [55:0] period_word(input int delta, input bit seen, input int x,
                                                input int y, input int z, input logic [3:0] obs);
        logic [12:0] xs, ys, zs;
        xs = x[12:0];
        ys = y[12:0];
        zs = z[12:0];
        return {4'd0, obs, zs, ys, xs, seen, delta[7:0]};
    endfunction

    // One APB transfer: setup, access, then an idle phase
    task automatic apb_access(input bit wr, input mdm_pkg::t_reg_idx idx,
                              input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Read back all four registers
    task automatic read_all_regs();
        apb_access(1'b0, mdm_pkg::REG_DRIVE_MODE, '0);
        apb_access(1'b0, mdm_pkg::REG_MAX_PWM, '0);
        apb_access(1'b0, mdm_pkg::REG_CMD_TMO, '0);
        apb_access(1'b0, mdm_pkg::REG_AVOID_HOLD, '0);
    endtask

    // Send one word after a random gap and hold it until accepted
    task automatic drive_period(input logic [55:0] w);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Result side: random stall before taking each word
    initial begin
        int gap;
        forever begin
            gap = idle_on ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Main stimulus
    initial begin
        logic [31:0] mode_v, pwm_v, tmo_v, hold_v;
        logic [3:0]  obs;
        int          n_items, seen_pct, pause_at, delta, x, y, z;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_all_regs();

        // remote mode at reset settings: extremes, wrap, each guard term
        drive_period(period_word(0, 1, 0, 0, 0, OBS_NONE));
        drive_period(period_word(255, 1, 3000, 3000, 3000, OBS_NONE));
        drive_period(period_word(1, 1, -3000, -3000, -3000, OBS_NONE));
        drive_period(period_word(0, 1, 4095, 4095, 4095, OBS_NONE));
        drive_period(period_word(0, 1, -4096, -4096, -4096, OBS_NONE));
        drive_period(period_word(0, 1, 3000, 0, 0, OBS_LD));
        drive_period(period_word(0, 1, 0, 3000, 0, OBS_LU));
        drive_period(period_word(0, 1, 0, -3000, 0, OBS_RD));
        drive_period(period_word(0, 1, 0, 3000, 0, OBS_RU));
        // link lost in remote mode
        drive_period(period_word(255, 0, 1234, -2000, 500, OBS_NONE));
        drive_period(period_word(0, 0, 1000, 0, 0, OBS_ALL));

        // self mode: cruise, left and right back-off, guard on back-off
        drain_results();
        apb_access(1'b1, mdm_pkg::REG_DRIVE_MODE, SELF_DRIVE);
        apb_access(1'b1, mdm_pkg::REG_CMD_TMO, 32'd0);
        apb_access(1'b1, mdm_pkg::REG_AVOID_HOLD, 32'd1000);
        read_all_regs();
        drive_period(period_word(1, 0, 0, 0, 0, OBS_NONE));
        drive_period(period_word(0, 0, 0, 0, 0, OBS_LU));
        drive_period(period_word(10, 0, 0, 0, 0, OBS_NONE));
        drive_period(period_word(255, 0, 0, 0, 0, OBS_RU));
        drive_period(period_word(255, 0, 0, 0, 0, OBS_LD));
        // run both timers out: left, right, then cruise
        repeat (4) drive_period(period_word(255, 0, 0, 0, 0, OBS_NONE));

        // zero hold: reload leaves no back-off, cruise hits the front guard
        drain_results();
        apb_access(1'b1, mdm_pkg::REG_AVOID_HOLD, 32'd0);
        drive_period(period_word(0, 0, 0, 0, 0, OBS_LU));
        drive_period(period_word(0, 0, 0, 0, 0, OBS_RU));
        drive_period(period_word(0, 1, 100, 200, 300, OBS_NONE));

        // zero full scale, then full scale with upper value bits dropped
        drain_results();
        apb_access(1'b1, mdm_pkg::REG_MAX_PWM, 32'd0);
        drive_period(period_word(0, 1, 3000, -3000, 1234, OBS_NONE));
        drain_results();
        apb_access(1'b1, mdm_pkg::REG_MAX_PWM, 32'hFFFF_FFFF);
        read_all_regs();
        drive_period(period_word(0, 1, 4095, 4095, -4096, OBS_NONE));

        // random phases, each with its own register settings
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            mode_v = $urandom_range(0, 1) ? SELF_DRIVE : REMOTE_PWM;
            case ($urandom_range(0, 3))
                0:       pwm_v = 32'd0;
                1:       pwm_v = 32'd10000;
                2:       pwm_v = 32'd16383;
                default: pwm_v = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       tmo_v = 32'd0;
                1:       tmo_v = 32'd150;
                2:       tmo_v = 32'd65535;
                default: tmo_v = $urandom_range(0, 2000) | ($urandom << 16);
            endcase
            case ($urandom_range(0, 3))
                0:       hold_v = 32'd0;
                1:       hold_v = 32'd1000;
                2:       hold_v = 32'd65535;
                default: hold_v = $urandom_range(0, 3000) | ($urandom << 16);
            endcase
            case ($urandom_range(0, 2))
                0:       seen_pct = 50;
                1:       seen_pct = 5;
                default: seen_pct = 0;
            endcase
            // one phase saturates the command age with the link held alive
            if (p == 2) begin
                tmo_v    = 32'd65535;
                seen_pct = 0;
            end
            apb_access(1'b1, mdm_pkg::REG_DRIVE_MODE, mode_v);
            apb_access(1'b1, mdm_pkg::REG_MAX_PWM, pwm_v);
            apb_access(1'b1, mdm_pkg::REG_CMD_TMO, tmo_v);
            apb_access(1'b1, mdm_pkg::REG_AVOID_HOLD, hold_v);
            read_all_regs();

            n_items  = (p == 2) ? 300 : 240;
            pause_at = $urandom_range(0, n_items - 1);
            for (int k = 0; k < n_items; k++) begin
                if ($urandom_range(0, 99) == 0) idle_on = !idle_on;
                if (k == pause_at) drain_results();
                case ($urandom_range(0, 3))
                    0:       delta = 255;
                    1:       delta = $urandom_range(0, 15);
                    default: delta = $urandom_range(0, 255);
                endcase
                if (p == 2) delta = 255;
                // mostly in-range speeds, sometimes any 13-bit pattern
                if ($urandom_range(0, 7) == 0) begin
                    x = $urandom;
                    y = $urandom;
                    z = $urandom;
                end else begin
                    x = $urandom_range(0, 6000) - 3000;
                    y = $urandom_range(0, 6000) - 3000;
                    z = $urandom_range(0, 6000) - 3000;
                end
                for (int b = 0; b < 4; b++) obs[b] = ($urandom_range(0, 3) == 0);
                drive_period(period_word(delta, $urandom_range(0, 99) < seen_pct,
                                         x, y, z, obs));
            end
        end

        // wait out the pipeline, then give the verdict
        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
